>>> src/cdq_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cdq_pkg
// Shared widths, command and status codes and the per-command result record
// of the circular deque.
// ---------------------------------------------------------------------------
package cdq_pkg;

	// fixed field widths
	localparam int CMD_W      = 3;
	localparam int DATA_IN_W  = 32;
	localparam int DATA_OUT_W = 32;
	localparam int STATUS_W   = 2;
	localparam int LEN_W      = 5;
	localparam int CAP_CFG_W  = 5;

	// defaults for the top-level parameters
	localparam int DEF_DEPTH      = 16;
	localparam int DEF_DATA_WIDTH = 32;
	localparam int CAP_RESET      = 16;

	// stream packing
	localparam int S_TDATA_W  = 32;
	localparam int M_TDATA_W  = 40;
	localparam int M_LEN_LSB  = DATA_OUT_W;
	localparam int M_EMPTY_B  = M_LEN_LSB + LEN_W;
	localparam int M_FULL_B   = M_EMPTY_B + 1;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_REAR  = 3'd0,
		CMD_POP_FRONT  = 3'd1,
		CMD_PUSH_FRONT = 3'd2,
		CMD_POP_REAR   = 3'd3,
		CMD_CLEAR      = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// outcome of one command, handed from the control unit to the output side
	typedef struct packed {
		logic             pop_ok;
		status_t          status;
		logic [LEN_W-1:0] length;
		logic             is_empty;
		logic             is_full;
	} res_t;

endpackage

>>> src/cdq_mem.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cdq_mem
// Slot store of the deque: one shared address, synchronous write and a
// registered read that holds its data until the next read.
// ---------------------------------------------------------------------------
module cdq_mem #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [DATA_WIDTH-1:0]    wdata,
	output logic [DATA_WIDTH-1:0]    rdata
);

	logic [DATA_WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

>>> src/cdq_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cdq_ctrl
// Ring pointers, fill count and capacity of the deque. Decodes each accepted
// command, steers the slot store and produces the command's result record.
// ---------------------------------------------------------------------------
module cdq_ctrl #(
	parameter int DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [cdq_pkg::CAP_CFG_W-1:0] cfg_wdata,
	input  logic                          cmd_valid,
	input  logic [cdq_pkg::CMD_W-1:0]     cmd,
	output cdq_pkg::res_t                 res,
	output logic                          mem_we,
	output logic                          mem_re,
	output logic [$clog2(DEPTH)-1:0]      mem_addr
);
	import cdq_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CAP_W = $clog2(DEPTH + 1);
	localparam int CAP_INIT = (CAP_RESET < DEPTH) ? CAP_RESET : DEPTH;

	logic [CAP_W-1:0] cap_q;
	logic [IDX_W-1:0] head_q, tail_q;
	logic [CAP_W-1:0] len_q;

	logic [IDX_W-1:0] head_nxt, tail_nxt;
	logic [CAP_W-1:0] len_nxt, cap_new;
	logic [IDX_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
	logic [CAP_W:0]   head_p1, tail_p1;
	logic             is_full, is_empty, pop_ok;
	status_t          status;

	assign is_full  = (len_q == cap_q);
	assign is_empty = (len_q == '0);

	// pointer steps wrap against the capacity in use
	assign head_p1  = (CAP_W+1)'(head_q) + 1'b1;
	assign tail_p1  = (CAP_W+1)'(tail_q) + 1'b1;
	assign head_inc = (head_p1 >= (CAP_W+1)'(cap_q)) ? '0 : IDX_W'(head_p1);
	assign tail_inc = (tail_p1 >= (CAP_W+1)'(cap_q)) ? '0 : IDX_W'(tail_p1);
	assign head_dec = (head_q == '0) ? IDX_W'(cap_q - 1'b1) : head_q - 1'b1;
	assign tail_dec = (tail_q == '0) ? IDX_W'(cap_q - 1'b1) : tail_q - 1'b1;

	always_comb begin
		head_nxt = head_q;
		tail_nxt = tail_q;
		len_nxt  = len_q;
		status   = ST_OK;
		pop_ok   = 1'b0;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		mem_addr = head_q;
		unique case (cmd)
			CMD_PUSH_REAR, CMD_PUSH_FRONT: begin
				if (is_full) begin
					status = ST_FULL;
				end else if (is_empty) begin
					head_nxt = '0;
					tail_nxt = '0;
					len_nxt  = CAP_W'(1);
					mem_we   = cmd_valid;
					mem_addr = '0;
				end else if (cmd == CMD_PUSH_REAR) begin
					tail_nxt = tail_inc;
					len_nxt  = len_q + 1'b1;
					mem_we   = cmd_valid;
					mem_addr = tail_inc;
				end else begin
					head_nxt = head_dec;
					len_nxt  = len_q + 1'b1;
					mem_we   = cmd_valid;
					mem_addr = head_dec;
				end
			end
			CMD_POP_FRONT, CMD_POP_REAR: begin
				if (is_empty) begin
					status = ST_EMPTY;
				end else begin
					pop_ok   = 1'b1;
					mem_re   = cmd_valid;
					mem_addr = (cmd == CMD_POP_FRONT) ? head_q : tail_q;
					len_nxt  = len_q - 1'b1;
					if (len_q == CAP_W'(1)) begin
						head_nxt = '0;
						tail_nxt = '0;
					end else if (cmd == CMD_POP_FRONT) begin
						head_nxt = head_inc;
					end else begin
						tail_nxt = tail_dec;
					end
				end
			end
			CMD_CLEAR: begin
				head_nxt = '0;
				tail_nxt = '0;
				len_nxt  = '0;
			end
			default: begin
			end
		endcase
	end

	assign res.pop_ok   = pop_ok;
	assign res.status   = status;
	assign res.length   = LEN_W'(len_nxt);
	assign res.is_empty = (len_nxt == '0);
	assign res.is_full  = (len_nxt == cap_q);

	// zero reads as one, anything past the store as the full depth
	always_comb begin
		if (cfg_wdata == '0) begin
			cap_new = CAP_W'(1);
		end else if (32'(cfg_wdata) > 32'(DEPTH)) begin
			cap_new = CAP_W'(DEPTH);
		end else begin
			cap_new = CAP_W'(cfg_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CAP_W'(CAP_INIT);
			head_q <= '0;
			tail_q <= '0;
			len_q  <= '0;
		end else if (cfg_wr_en) begin
			cap_q  <= cap_new;
			head_q <= '0;
			tail_q <= '0;
			len_q  <= '0;
		end else if (cmd_valid) begin
			head_q <= head_nxt;
			tail_q <= tail_nxt;
			len_q  <= len_nxt;
		end
	end

endmodule

>>> src/circular_deque_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// circular_deque_core
// Double-ended queue in a ring of slots with a configurable capacity in use.
// ---------------------------------------------------------------------------
//  channel   dir  handshake          contents
//  s_*       in   s_tvalid/s_tready  tuser cmd, tdata data_in
//  m_*       out  m_tvalid/m_tready  tuser status, tdata result fields
//  cfg_*     in   cfg_wr_en          capacity
//
//  One command per cycle while the output is not stalled; a result is
//  registered in stage one with the slot store read, then in the output register.
//  Pointers and count update at acceptance, so a pop right after a push to
//  the same slot reads the new data with no interlock.
//  A stalled output holds the pending command in stage one and stops input.
//  Reset empties the queue and sets the capacity to sixteen, or to DEPTH
//  if that is smaller; slots are not cleared.
// ---------------------------------------------------------------------------
module circular_deque_core #(
	parameter int DEPTH      = cdq_pkg::DEF_DEPTH,
	parameter int DATA_WIDTH = cdq_pkg::DEF_DATA_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [cdq_pkg::CAP_CFG_W-1:0] cfg_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [cdq_pkg::S_TDATA_W-1:0] s_tdata,   // data_in
	input  logic [cdq_pkg::CMD_W-1:0]     s_tuser,   // cmd
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// data_out, length, is_empty, is_full, zero pad
	output logic [cdq_pkg::M_TDATA_W-1:0] m_tdata,
	output logic [cdq_pkg::STATUS_W-1:0]  m_tuser    // status
);
	import cdq_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);

	logic                  accept, adv_s1, valid_s1;
	res_t                  res, res_s1;
	logic                  mem_we, mem_re;
	logic [IDX_W-1:0]      mem_addr;
	logic [DATA_WIDTH-1:0] wdata, rdata;
	logic [63:0]           din_ext, rdata_ext;
	logic [DATA_OUT_W-1:0] dout;

	assign adv_s1   = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || !m_tvalid || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign din_ext   = {{(64-DATA_IN_W){1'b0}}, s_tdata};
	assign wdata     = din_ext[DATA_WIDTH-1:0];
	assign rdata_ext = {{(64-DATA_WIDTH){1'b0}}, rdata};
	assign dout      = res_s1.pop_ok ? rdata_ext[DATA_OUT_W-1:0] : '0;

	cdq_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wdata(cfg_wdata),
		.cmd_valid(accept),
		.cmd      (s_tuser),
		.res      (res),
		.mem_we   (mem_we),
		.mem_re   (mem_re),
		.mem_addr (mem_addr)
	);

	cdq_mem #(
		.DEPTH     (DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.re   (mem_re),
		.addr (mem_addr),
		.wdata(wdata),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv_s1) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			m_tdata <= {1'b0, res_s1.is_full, res_s1.is_empty, res_s1.length, dout};
			m_tuser <= res_s1.status;
		end
	end

	// a rejected push only happens on a full queue
	a_full_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_FULL) |-> m_tdata[M_FULL_B])
		else $error("push rejected while queue not full");

	// a rejected pop only happens on an empty queue and returns no data
	a_empty_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_EMPTY) |->
		(m_tdata[M_EMPTY_B] && m_tdata[DATA_OUT_W-1:0] == '0))
		else $error("pop rejected while queue not empty");

	// empty flag agrees with the reported length
	a_empty_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[M_EMPTY_B] == (m_tdata[M_EMPTY_B-1:M_LEN_LSB] == '0)))
		else $error("empty flag and length disagree");

	// a result leaves stage one only into a free or draining output register
	a_s1_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && m_tvalid && !m_tready) |=> valid_s1)
		else $error("pending request lost under output stall");

endmodule
